### design/rtq_pkg.sv
// Shared types and constants for the reloading timer queue.
package rtq_pkg;

  localparam int TIMERS_DEF   = 16;
  localparam int MAX_FIRE_DEF = 16;
  localparam int RESULT_CAP   = 16;
  localparam int TIME_W       = 48;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DEL     = 2'd1,
    OP_DEL_ALL = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transfer
    logic scan_start; // clear scan accumulators
    logic scan_step;  // examine one entry
    logic do_add;     // write add result
    logic do_del;     // invalidate found entry
    logic do_clr;     // invalidate all entries
    logic do_tick;    // advance time
    logic do_fire;    // rearm or remove best entry
    logic hold;       // park best entry's id and tag until last is known
    logic emit;       // load output register
    logic emit_last;
    kind_t emit_kind;
  } rtq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic found;
    logic due_found;
    logic out_busy;
  } rtq_sts_t;

endpackage

### design/rtq_datapath.sv
// Timer table, scan logic, time counter and result register.
module rtq_datapath #(
  parameter int TIMERS = rtq_pkg::TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rtq_pkg::rtq_cmd_t cmd,
  output rtq_pkg::rtq_sts_t sts,
  input  logic [1:0]        in_op,
  input  logic [119:0]      in_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic [23:0]       out_tdata,
  output logic              out_tlast
);
  import rtq_pkg::*;

  localparam int IW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);

  logic [TIMERS-1:0] vld_r, vld_nxt;
  logic [7:0]  id_m   [TIMERS];
  logic [47:0] exp_m  [TIMERS];
  logic [31:0] rel_m  [TIMERS];
  logic [15:0] tag_m  [TIMERS];

  op_t         op_r;
  logic [7:0]  tid_r;
  logic [32:0] dsum_r;
  logic [31:0] rp_r;
  logic [15:0] tg_r;
  logic [47:0] now_r;

  logic [CW-1:0] idx_r;
  logic [IW-1:0] idx;
  logic          found_r, free_ok_r, due_r;
  logic [IW-1:0] hit_r, free_r, best_r;
  logic [47:0]   bexp_r;
  logic [7:0]    bid_r;

  logic [7:0]  pid_r;
  logic [15:0] ptag_r;

  logic        ov_r;
  kind_t       okind_r;
  logic [23:0] od_r;
  logic        ol_r;

  logic [47:0] sum_add, sum_fire;
  logic [48:0] s1, s2;
  logic [IW-1:0] wslot;

  assign idx = idx_r[IW-1:0];
  assign s1  = {1'b0, now_r} + {16'd0, dsum_r};
  assign sum_add = s1[48] ? TIME_MAX : s1[47:0];
  assign s2  = {1'b0, exp_m[best_r]} + {17'd0, rel_m[best_r]};
  assign sum_fire = s2[48] ? TIME_MAX : s2[47:0];
  assign wslot = found_r ? hit_r : free_r;

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.do_add && (found_r || free_ok_r)) vld_nxt[wslot] = 1'b1;
    if (cmd.do_del && found_r) vld_nxt[hit_r] = 1'b0;
    if (cmd.do_clr) vld_nxt = '0;
    if (cmd.do_fire && rel_m[best_r] == 32'd0) vld_nxt[best_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      now_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (cmd.do_tick) now_r <= now_r + 48'd1;
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      tid_r  <= in_data[7:0];
      dsum_r <= {1'b0, in_data[39:8]} + {1'b0, in_data[71:40]};
      rp_r   <= in_data[103:72];
      tg_r   <= in_data[119:104];
    end
    if (cmd.do_add && (found_r || free_ok_r)) begin
      id_m[wslot]  <= tid_r;
      exp_m[wslot] <= sum_add;
      rel_m[wslot] <= rp_r;
      tag_m[wslot] <= tg_r;
    end
    if (cmd.do_fire && rel_m[best_r] != 32'd0) exp_m[best_r] <= sum_fire;
    if (cmd.hold) begin
      pid_r  <= id_m[best_r];
      ptag_r <= tag_m[best_r];
    end
    if (cmd.emit) begin
      ol_r    <= cmd.emit_last;
      okind_r <= cmd.emit_kind;
      unique case (cmd.emit_kind)
        KIND_FIRED: od_r <= {ptag_r, pid_r};
        KIND_FULL:  od_r <= {16'd0, tid_r};
        default:    od_r <= {16'd0, (op_r == OP_DEL_ALL) ? 8'd0 : tid_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r <= '0;
      found_r <= 1'b0;
      free_ok_r <= 1'b0;
      due_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + CW'(1);
      if (vld_r[idx]) begin
        if (id_m[idx] == tid_r) begin
          found_r <= 1'b1;
          hit_r <= idx;
        end
        if (exp_m[idx] <= now_r &&
            (!due_r || exp_m[idx] < bexp_r ||
             (exp_m[idx] == bexp_r && id_m[idx] < bid_r))) begin
          due_r <= 1'b1;
          best_r <= idx;
          bexp_r <= exp_m[idx];
          bid_r <= id_m[idx];
        end
      end else if (!free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r <= idx;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.scan_done = (idx_r == CW'(TIMERS));
  assign sts.found     = found_r | free_ok_r;
  assign sts.due_found = due_r;
  assign sts.out_busy  = ov_r & ~out_tready;

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
endmodule

### design/rtq_ctrl.sv
// Sequencing state machine for operations and tick firing.
module rtq_ctrl #(
  parameter int MAX_FIRE = rtq_pkg::MAX_FIRE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rtq_pkg::rtq_sts_t sts,
  output rtq_pkg::rtq_cmd_t cmd
);
  import rtq_pkg::*;

  localparam int CAP = (MAX_FIRE < RESULT_CAP) ? MAX_FIRE : RESULT_CAP;
  localparam int NW  = $clog2(CAP + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_ACT  = 5'b00100,
    S_FIRE = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    cmd = '0;
    cmd.emit_kind = KIND_DONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_WAIT;
          n_nxt = '0;
        end
      end
      S_WAIT: begin
        cmd.scan_start = 1'b1;
        if (sts.op == OP_TICK) cmd.do_tick = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = (sts.op == OP_TICK) ? S_FIRE : S_ACT;
        else cmd.scan_step = 1'b1;
      end
      S_ACT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          unique case (sts.op)
            OP_ADD: begin
              cmd.do_add = 1'b1;
              cmd.emit_kind = sts.found ? KIND_DONE : KIND_FULL;
            end
            OP_DEL: cmd.do_del = 1'b1;
            default: cmd.do_clr = 1'b1;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        if (n_r == '0) begin
          if (!sts.due_found) state_nxt = S_IDLE;
          else begin
            cmd.do_fire = 1'b1;
            cmd.hold = 1'b1;
            cmd.scan_start = 1'b1;
            n_nxt = n_r + NW'(1);
            state_nxt = (n_nxt == NW'(CAP)) ? S_FIRE : S_SCAN;
          end
        end else if (!sts.out_busy) begin
          // held firing goes out; last once nothing more is due or the cap is reached
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_FIRED;
          if (n_r == NW'(CAP) || !sts.due_found) begin
            cmd.emit_last = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.do_fire = 1'b1;
            cmd.hold = 1'b1;
            cmd.scan_start = 1'b1;
            n_nxt = n_r + NW'(1);
            state_nxt = (n_nxt == NW'(CAP)) ? S_FIRE : S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
    end
  end
endmodule

### design/reloading_timer_queue.sv
// Top level of the reloading timer queue.
// Add, delete and delete-all: the input transfer, a wait state, a full table scan, then the act
// state loads the result. One item at a time; the scan examines one entry per cycle.
// In a tick each firing is held until the next scan shows whether another is due; when the
// cap is reached the last firing goes out without another scan. Output stalls delay results.
// Reset: synchronous active-low rst_n clears time, valid bits, the output valid flag and the controller.
module reloading_timer_queue #(
  parameter int TIMERS   = rtq_pkg::TIMERS_DEF,
  parameter int MAX_FIRE = rtq_pkg::MAX_FIRE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,  // op
  input  logic [119:0] in_tdata,  // timer_id, start_delay, expire_delay, reload_period, tag
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [1:0]   out_tuser, // kind
  output logic [23:0]  out_tdata, // fired_id, fired_tag
  output logic         out_tlast
);
  import rtq_pkg::*;

  rtq_cmd_t cmd;
  rtq_sts_t sts;

  rtq_ctrl #(.MAX_FIRE(MAX_FIRE)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd
  );

  rtq_datapath #(.TIMERS(TIMERS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op(in_tuser), .in_data(in_tdata),
    .out_tvalid, .out_tready, .out_tuser, .out_tdata, .out_tlast
  );
endmodule
